FILE: hw/rtl/conservative_to_roe_vector_defines.svh
// ----------------------------------------------------------------------------
// conservative_to_roe_vector_defines
// assertion macros shared by the roe vector rtl
// ----------------------------------------------------------------------------
`ifndef CONSERVATIVE_TO_ROE_VECTOR_DEFINES_SVH
`define CONSERVATIVE_TO_ROE_VECTOR_DEFINES_SVH

// same-cycle implication, checked on every clock edge outside reset
`define C2R_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on every clock edge outside reset
`define C2R_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/c2r_pkg.sv
// ----------------------------------------------------------------------------
// c2r_pkg
// shared constants of the conservative to roe vector block
// ----------------------------------------------------------------------------
package c2r_pkg;

  // default data word format, q16.16 in a 32 bit word
  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;

  // heat ratio register, unsigned q2.16 in 18 bits, reset 1.4
  localparam int GAMMA_W = 18;
  localparam logic [GAMMA_W-1:0] GAMMA_RESET = 18'd91750;

  // lanes divided by the root: x, y, z momentum, k term, omega term
  localparam int NUM_LANES = 5;
  localparam int LANE_MX = 0;
  localparam int LANE_MY = 1;
  localparam int LANE_MZ = 2;
  localparam int LANE_K  = 3;
  localparam int LANE_OM = 4;

endpackage

FILE: hw/rtl/c2r_channels.sv
// ----------------------------------------------------------------------------
// c2r_channels
// valid/ready channels for cell beats in and roe vector beats out
// ----------------------------------------------------------------------------
interface c2r_cell_if import c2r_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic        [WORD_BITS-2:0] density;
  logic signed [WORD_BITS-1:0] momentum_x;
  logic signed [WORD_BITS-1:0] momentum_y;
  logic signed [WORD_BITS-1:0] momentum_z;
  logic signed [WORD_BITS-1:0] total_energy;
  logic signed [WORD_BITS-1:0] turb_energy;
  logic signed [WORD_BITS-1:0] turb_rate;

  modport source (
    output valid, density, momentum_x, momentum_y, momentum_z,
           total_energy, turb_energy, turb_rate,
    input  ready
  );
  modport sink (
    input  valid, density, momentum_x, momentum_y, momentum_z,
           total_energy, turb_energy, turb_rate,
    output ready
  );
endinterface

interface c2r_roe_if import c2r_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic        [WORD_BITS-2:0] sqrt_density;
  logic signed [WORD_BITS-1:0] roe_u;
  logic signed [WORD_BITS-1:0] roe_v;
  logic signed [WORD_BITS-1:0] roe_w;
  logic signed [WORD_BITS-1:0] roe_enthalpy;
  logic signed [WORD_BITS-1:0] roe_k;
  logic signed [WORD_BITS-1:0] roe_omega;
  logic                        bad_density;

  modport source (
    output valid, sqrt_density, roe_u, roe_v, roe_w, roe_enthalpy,
           roe_k, roe_omega, bad_density,
    input  ready
  );
  modport sink (
    input  valid, sqrt_density, roe_u, roe_v, roe_w, roe_enthalpy,
           roe_k, roe_omega, bad_density,
    output ready
  );
endinterface

FILE: hw/rtl/c2r_sqrt.sv
// ----------------------------------------------------------------------------
// c2r_sqrt
// pipelined integer square root, one root bit per register stage
// ----------------------------------------------------------------------------
module c2r_sqrt import c2r_pkg::*; #(
  parameter int RAD_W = WORD_BITS_DEF - 1 + FRAC_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [RAD_W-1:0]         rad_i,
  output logic [(RAD_W+1)/2-1:0]   root_o
);

  localparam int RT_W  = (RAD_W + 1) / 2;
  localparam int X_W   = 2 * RT_W;
  localparam int REM_W = RT_W + 2;

  logic [REM_W-1:0] rem_q  [RT_W];
  logic [RT_W-1:0]  root_q [RT_W];
  logic [X_W-1:0]   x_q    [RT_W];

  for (genvar k = 0; k < RT_W; k++) begin : g_step
    logic [REM_W-1:0] rem_p;
    logic [RT_W-1:0]  root_p;
    logic [X_W-1:0]   x_p;
    logic [REM_W-1:0] rem_t;
    logic [REM_W-1:0] trial;
    logic             take;

    // previous stage, or the radicand at the head
    if (k == 0) begin : g_head
      assign rem_p  = '0;
      assign root_p = '0;
      assign x_p    = X_W'(rad_i);
    end else begin : g_body
      assign rem_p  = rem_q[k-1];
      assign root_p = root_q[k-1];
      assign x_p    = x_q[k-1];
    end

    // bring down two radicand bits and try root*4+1
    assign rem_t = {rem_p[REM_W-3:0], x_p[X_W-1 -: 2]};
    assign trial = {root_p, 2'b01};
    assign take  = rem_t >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= take ? rem_t - trial : rem_t;
        root_q[k] <= {root_p[RT_W-2:0], take};
        x_q[k]    <= x_p << 2;
      end
    end
  end

  assign root_o = root_q[RT_W-1];

endmodule

FILE: hw/rtl/c2r_div.sv
// ----------------------------------------------------------------------------
// c2r_div
// pipelined restoring divider, one quotient bit per stage, overflow flag
// ----------------------------------------------------------------------------
module c2r_div import c2r_pkg::*; #(
  parameter int N_W = WORD_BITS_DEF + FRAC_BITS_DEF,
  parameter int D_W = WORD_BITS_DEF,
  parameter int Q_W = WORD_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [N_W-1:0] num_i,
  input  logic [D_W-1:0] den_i,
  output logic [Q_W-1:0] quot_o,
  output logic           ovf_o
);

  localparam int H_W = N_W - Q_W;
  localparam int C_W = (H_W > D_W) ? H_W : D_W;

  logic [D_W-1:0] rem_q [Q_W+1];
  logic [Q_W-1:0] low_q [Q_W+1];
  logic [Q_W-1:0] quo_q [Q_W+1];
  logic [D_W-1:0] den_q [Q_W+1];
  logic           ovf_q [Q_W+1];

  logic [C_W-1:0] hi_ext;
  logic [C_W-1:0] den_ext;

  // load: quotient too wide when the high part already reaches the divisor
  assign hi_ext  = C_W'(num_i[N_W-1:Q_W]);
  assign den_ext = C_W'(den_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= hi_ext[D_W-1:0];
      low_q[0] <= num_i[Q_W-1:0];
      quo_q[0] <= '0;
      den_q[0] <= den_i;
      ovf_q[0] <= hi_ext >= den_ext;
    end
  end

  for (genvar k = 1; k <= Q_W; k++) begin : g_step
    logic [D_W:0] trial;
    logic [D_W:0] diff;
    logic         take;

    // shift in the next numerator bit and subtract when it fits
    assign trial = {rem_q[k-1], low_q[k-1][Q_W-1]};
    assign diff  = trial - {1'b0, den_q[k-1]};
    assign take  = trial >= {1'b0, den_q[k-1]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= take ? diff[D_W-1:0] : trial[D_W-1:0];
        low_q[k] <= low_q[k-1] << 1;
        quo_q[k] <= {quo_q[k-1][Q_W-2:0], take};
        den_q[k] <= den_q[k-1];
        ovf_q[k] <= ovf_q[k-1];
      end
    end
  end

  assign quot_o = quo_q[Q_W];
  assign ovf_o  = ovf_q[Q_W];

endmodule

FILE: hw/rtl/conservative_to_roe_vector.sv
// throughput: one beat per cycle unless roe_o.ready stalls a full output;
//   the path through the density quotient divider and the final enthalpy
//   divider, one bit per stage, sets the depth
// reset: valid bits clear at once, heat ratio returns to 1.4, data regs unreset
// ----------------------------------------------------------------------------
// conservative_to_roe_vector
// roe parameter vector of one 3d euler k-omega cell, q16.16, saturated
// ----------------------------------------------------------------------------
`include "conservative_to_roe_vector_defines.svh"

module conservative_to_roe_vector import c2r_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  c2r_cell_if.sink           cell_i,
  c2r_roe_if.source          roe_o,
  input  logic               heat_ratio_we_i,
  input  logic [GAMMA_W-1:0] heat_ratio_i
);

  localparam int W     = WORD_BITS;
  localparam int F     = FRAC_BITS;
  localparam int D_W   = W - 1;
  localparam int RAD_W = D_W + F;
  localparam int RT_W  = (RAD_W + 1) / 2;
  localparam int NUM_W = W + F;
  localparam int S_W   = 2 * W;
  localparam int QD_W  = 2 * W - 2;
  localparam int QL_W  = QD_W / 2;
  localparam int QH_W  = QD_W - QL_W;
  localparam int HM_W  = (GAMMA_W > F + 1) ? GAMMA_W : F + 1;
  localparam int PL_W  = HM_W + QL_W;
  localparam int PH_W  = HM_W + QH_W;
  localparam int P_W   = HM_W + QD_W + 1;
  localparam int B_W   = 2 * W - 2;
  localparam int A_W   = GAMMA_W + W;
  localparam int N2_W  = ((A_W > B_W) ? A_W : B_W) + 2;

  // schedule, in cycles after the input register
  localparam int T_S = RT_W;
  localparam int T_M = T_S + W + 1;
  localparam int T_Q = 2 * W + 2;
  localparam int T_N = T_Q + 4;
  localparam int T_H = T_N + W + 1;
  localparam int T_O = T_H + 1;

  localparam int LEN_SD = T_H - 1;
  localparam int LEN_AC = T_Q - 1;
  localparam int LEN_SC = T_H - T_S;
  localparam int LEN_MQ = T_H - T_M;
  localparam int LEN_HN = T_H - T_N;

  localparam logic [P_W-2:0] CLAMP_P = (P_W-1)'(1) << (2 * W - 3);
  localparam logic [B_W-1:0] CLAMP_B = {1'b1, {(B_W-1){1'b0}}};

  typedef struct packed {
    logic                            bad;
    logic [D_W-1:0]                  dens;
    logic                            e_neg;
    logic [W-1:0]                    e_mag;
    logic [NUM_LANES-1:0]            neg;
    logic [NUM_LANES-1:0][W-1:0]     mag;
  } side_t;

  typedef struct packed {
    logic [NUM_LANES-1:0]            ovf;
    logic [NUM_LANES-1:0][W-1:0]     quo;
  } lane_res_t;

  function automatic logic [W-1:0] sat_word(input logic neg, input logic ovf,
                                            input logic [W-1:0] mag);
    logic [W-1:0] lim;
    logic [W-1:0] res;
    lim = {1'b1, {(W-1){1'b0}}};
    if (neg) begin
      res = (ovf || mag > lim) ? lim : (~mag + 1'b1);
    end else begin
      res = (ovf || mag[W-1]) ? ~lim : mag;
    end
    return res;
  endfunction

  function automatic logic [W-1:0] abs_word(input logic [W-1:0] v);
    return v[W-1] ? (~v + 1'b1) : v;
  endfunction

  // heat ratio register
  logic [GAMMA_W-1:0] heat_ratio_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heat_ratio_q <= GAMMA_RESET;
    end else if (heat_ratio_we_i) begin
      heat_ratio_q <= heat_ratio_i;
    end
  end

  // gamma - one as sign and magnitude
  logic [HM_W-1:0] g_ext;
  logic [HM_W-1:0] one_c;
  logic [HM_W-1:0] hmag;
  logic            hneg;

  assign g_ext = HM_W'(heat_ratio_q);
  assign one_c = HM_W'(1) << F;
  assign hneg  = g_ext < one_c;
  assign hmag  = hneg ? one_c - g_ext : g_ext - one_c;

  // valid bits and stall control
  logic [T_O:0] vld_q;
  logic         adv;
  logic         en0;

  assign adv          = ~vld_q[T_O] | roe_o.ready;
  assign en0          = adv | ~vld_q[0];
  assign cell_i.ready = en0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en0) vld_q[0] <= cell_i.valid;
      if (adv) vld_q[T_O:1] <= vld_q[T_O-1:0];
    end
  end

  // input register
  logic [D_W-1:0]            dens_q;
  logic [NUM_LANES-1:0][W-1:0] lane_in_q;
  logic [W-1:0]              energy_q;

  always_ff @(posedge clk_i) begin
    if (en0) begin
      dens_q             <= cell_i.density;
      lane_in_q[LANE_MX] <= cell_i.momentum_x;
      lane_in_q[LANE_MY] <= cell_i.momentum_y;
      lane_in_q[LANE_MZ] <= cell_i.momentum_z;
      lane_in_q[LANE_K]  <= cell_i.turb_energy;
      lane_in_q[LANE_OM] <= cell_i.turb_rate;
      energy_q           <= cell_i.total_energy;
    end
  end

  // square root of density scaled by one
  logic [RAD_W-1:0] rad;
  logic [RT_W-1:0]  root;

  assign rad = {dens_q, {F{1'b0}}};

  c2r_sqrt #(.RAD_W(RAD_W)) u_sqrt (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rad_i  (rad),
    .root_o (root)
  );

  // stage 1: sign and magnitude of every signed field
  side_t side1_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side1_q.bad   <= dens_q == '0;
      side1_q.dens  <= dens_q;
      side1_q.e_neg <= energy_q[W-1];
      side1_q.e_mag <= abs_word(energy_q);
      for (int l = 0; l < NUM_LANES; l++) begin
        side1_q.neg[l] <= lane_in_q[l][W-1];
        side1_q.mag[l] <= abs_word(lane_in_q[l]);
      end
    end
  end

  // side data delay line, entry j holds stage j+2
  side_t sd_q [LEN_SD];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sd_q[0] <= side1_q;
      for (int j = 1; j < LEN_SD; j++) sd_q[j] <= sd_q[j-1];
    end
  end

  // stage 2: momentum squares and gamma times energy
  logic [S_W-1:0] sq_q [3];
  logic [A_W-1:0] a_mag_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_q[0] <= S_W'(side1_q.mag[LANE_MX]) * S_W'(side1_q.mag[LANE_MX]);
      sq_q[1] <= S_W'(side1_q.mag[LANE_MY]) * S_W'(side1_q.mag[LANE_MY]);
      sq_q[2] <= S_W'(side1_q.mag[LANE_MZ]) * S_W'(side1_q.mag[LANE_MZ]);
      a_mag_q <= A_W'(heat_ratio_q) * A_W'(side1_q.e_mag);
    end
  end

  // stage 3: squared momentum sum and signed energy term
  logic        [S_W-1:0]  ssum_q;
  logic signed [N2_W-1:0] a_ext;
  logic signed [N2_W-1:0] a_sgn_q;

  assign a_ext = $signed(N2_W'(a_mag_q));

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ssum_q  <= sq_q[0] + sq_q[1] + sq_q[2];
      a_sgn_q <= sd_q[0].e_neg ? -a_ext : a_ext;
    end
  end

  // energy term waits for the kinetic term
  logic signed [N2_W-1:0] ac_q [LEN_AC];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ac_q[0] <= a_sgn_q;
      for (int j = 1; j < LEN_AC; j++) ac_q[j] <= ac_q[j-1];
    end
  end

  // squared momentum over density
  logic [QD_W-1:0] qd;
  logic            qd_ovf;

  c2r_div #(.N_W(S_W), .D_W(D_W), .Q_W(QD_W)) u_div_dens (
    .clk_i  (clk_i),
    .en_i   (adv),
    .num_i  (ssum_q),
    .den_i  (sd_q[1].dens),
    .quot_o (qd),
    .ovf_o  (qd_ovf)
  );

  // kinetic term: partial products, clamp, sum with energy, magnitude
  logic [PL_W-1:0]        pl_q;
  logic [PH_W-1:0]        ph_q;
  logic                   qovf_q;
  logic [P_W-1:0]         p_sum;
  logic [B_W-1:0]         bmag_q;
  logic signed [N2_W-1:0] b_ext;
  logic signed [N2_W-1:0] n_q;
  logic [N2_W-1:0]        nmag_q;
  logic                   nneg_q;

  assign p_sum = (P_W'(ph_q) << QL_W) + P_W'(pl_q);
  assign b_ext = $signed(N2_W'(bmag_q));

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pl_q   <= PL_W'(hmag) * PL_W'(qd[QL_W-1:0]);
      ph_q   <= PH_W'(hmag) * PH_W'(qd[QD_W-1:QL_W]);
      qovf_q <= qd_ovf;
      bmag_q <= ((qovf_q && (hmag != '0)) || (p_sum[P_W-1:1] > CLAMP_P)) ?
                CLAMP_B : B_W'(p_sum[P_W-1:1]);
      n_q    <= hneg ? ac_q[LEN_AC-1] + b_ext : ac_q[LEN_AC-1] - b_ext;
      nneg_q <= n_q[N2_W-1];
      nmag_q <= n_q[N2_W-1] ? N2_W'(-n_q) : N2_W'(n_q);
    end
  end

  // root delay line, entry j holds the root of stage T_S+1+j
  logic [RT_W-1:0] sc_q [LEN_SC];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sc_q[0] <= root;
      for (int j = 1; j < LEN_SC; j++) sc_q[j] <= sc_q[j-1];
    end
  end

  // lane quotients: field scaled by one over the root
  lane_res_t lane_res;

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    c2r_div #(.N_W(NUM_W), .D_W(RT_W), .Q_W(W)) u_div_lane (
      .clk_i  (clk_i),
      .en_i   (adv),
      .num_i  ({sd_q[T_S-2].mag[l], {F{1'b0}}}),
      .den_i  (root),
      .quot_o (lane_res.quo[l]),
      .ovf_o  (lane_res.ovf[l])
    );
  end

  lane_res_t mq_q [LEN_MQ];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mq_q[0] <= lane_res;
      for (int j = 1; j < LEN_MQ; j++) mq_q[j] <= mq_q[j-1];
    end
  end

  // enthalpy numerator over the root
  logic [W-1:0] h_quo;
  logic         h_ovf;
  logic         hn_q [LEN_HN];

  c2r_div #(.N_W(N2_W), .D_W(RT_W), .Q_W(W)) u_div_enth (
    .clk_i  (clk_i),
    .en_i   (adv),
    .num_i  (nmag_q),
    .den_i  (sc_q[T_N-T_S-1]),
    .quot_o (h_quo),
    .ovf_o  (h_ovf)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hn_q[0] <= nneg_q;
      for (int j = 1; j < LEN_HN; j++) hn_q[j] <= hn_q[j-1];
    end
  end

  // output register: saturate, zero everything on a bad density
  side_t        sd_h;
  lane_res_t    mq_h;
  logic [D_W-1:0] s_out_q;
  logic [NUM_LANES-1:0][W-1:0] lane_out_q;
  logic [W-1:0] enth_out_q;
  logic         bad_out_q;

  assign sd_h = sd_q[T_H-2];
  assign mq_h = mq_q[LEN_MQ-1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      bad_out_q <= sd_h.bad;
      if (sd_h.bad) begin
        s_out_q    <= '0;
        lane_out_q <= '0;
        enth_out_q <= '0;
      end else begin
        s_out_q    <= D_W'(sc_q[LEN_SC-1]);
        enth_out_q <= sat_word(hn_q[LEN_HN-1], h_ovf, h_quo);
        for (int l = 0; l < NUM_LANES; l++) begin
          lane_out_q[l] <= sat_word(sd_h.neg[l], mq_h.ovf[l], mq_h.quo[l]);
        end
      end
    end
  end

  assign roe_o.valid        = vld_q[T_O];
  assign roe_o.sqrt_density = s_out_q;
  assign roe_o.roe_u        = lane_out_q[LANE_MX];
  assign roe_o.roe_v        = lane_out_q[LANE_MY];
  assign roe_o.roe_w        = lane_out_q[LANE_MZ];
  assign roe_o.roe_enthalpy = enth_out_q;
  assign roe_o.roe_k        = lane_out_q[LANE_K];
  assign roe_o.roe_omega    = lane_out_q[LANE_OM];
  assign roe_o.bad_density  = bad_out_q;

  // assertions
  `C2R_ASSERT_IMP(a_bad_zero, clk_i, rst_ni, roe_o.valid && roe_o.bad_density,
    roe_o.sqrt_density == '0 && roe_o.roe_u == '0 && roe_o.roe_v == '0 && roe_o.roe_w == '0 && roe_o.roe_enthalpy == '0 && roe_o.roe_k == '0 && roe_o.roe_omega == '0,
    "bad density beat with nonzero fields")
  `C2R_ASSERT_IMP(a_root_nonzero, clk_i, rst_ni, roe_o.valid && !roe_o.bad_density,
    roe_o.sqrt_density != '0, "zero root on a positive density")
  `C2R_ASSERT_NXT(a_stall_hold, clk_i, rst_ni, !adv,
    $stable(vld_q[T_O:1]), "pipeline moved during a stall")
  `C2R_ASSERT_NXT(a_accept_load, clk_i, rst_ni, cell_i.valid && cell_i.ready,
    vld_q[0], "accepted beat missing from the input stage")

endmodule
